// ----- src/sfb_pkg.sv -----
`default_nettype none

package sfb_pkg;

    localparam int unsigned NUM_FIELDS  = 7;
    localparam int unsigned FIELD_W     = 16;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CRC_W       = 16;
    localparam int unsigned PAYLOAD_W   = NUM_FIELDS * FIELD_W;
    localparam int unsigned FRAME_BYTES = 19;
    localparam int unsigned IDX_W       = 5;

    typedef logic [IDX_W-1:0]  byte_idx_t;
    typedef logic [BYTE_W-1:0] frame_byte_t;
    typedef logic [CRC_W-1:0]  crc_t;

    // Frame layout
    localparam frame_byte_t HDR_SYNC0 = 8'h55;
    localparam frame_byte_t HDR_SYNC1 = 8'hAA;
    localparam frame_byte_t HDR_LEN   = 8'd17;

    localparam byte_idx_t IDX_SYNC0    = 5'd0;
    localparam byte_idx_t IDX_SYNC1    = 5'd1;
    localparam byte_idx_t IDX_LEN      = 5'd2;
    localparam byte_idx_t IDX_DATA0    = 5'd3;
    localparam byte_idx_t IDX_CRC_HI   = 5'd17;
    localparam byte_idx_t IDX_CRC_LO   = 5'd18;

    // Reflected CRC-16, no final XOR
    localparam crc_t CRC_INIT = 16'hFFFF;
    localparam crc_t CRC_POLY = 16'hA001;

endpackage

`default_nettype wire

// ----- src/sfb_crc_byte.sv -----
`default_nettype none

module sfb_crc_byte (
    input  wire  sfb_pkg::crc_t        crc_in,
    input  wire  sfb_pkg::frame_byte_t data,
    output sfb_pkg::crc_t              crc_out
);
    import sfb_pkg::*;

    // Fold one byte in, LSB first
    always_comb
    begin
        crc_t c;
        c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

`default_nettype wire

// ----- src/sensor_frame_builder_crc16.sv -----
// Sensor frame builder with CRC-16 check bytes.
//
// Input channel (in_valid / in_ready): one transaction carries seven 16-bit
// readings. Output channel (out_valid / out_ready): one transaction per
// frame byte, 19 per input item, in transmit order: 0x55, 0xAA, length 17,
// the seven readings high byte first, then the CRC high and low bytes.
// last_byte marks the CRC low byte.
//
// An accepted item is loaded into the shift register and frame counter; each
// frame byte then passes through the output register. Throughput: one frame
// byte per cycle while out_ready is high. The next item is taken in the same
// cycle that the last byte of the current frame enters the output register,
// so frames follow each other with no gap.
//
// The CRC (reflected, poly 0xA001, init 0xFFFF) is built up one byte per
// cycle as the bytes are sent, so the check bytes are ready when reached.
//
// Reset clears the busy flag, the frame counter and the output valid flag;
// no frame is in flight afterwards. When the receiver stalls, the output
// register holds its byte and the serialiser waits with it.
`default_nettype none

module sensor_frame_builder_crc16 (
    input  wire  clk,
    input  wire  rst_n,

    input  wire  in_valid,
    output logic in_ready,
    input  wire  [15:0] temperature,
    input  wire  [15:0] humidity,
    input  wire  [15:0] light_level,
    input  wire  [15:0] rain_index,
    input  wire  [15:0] fire_index,
    input  wire  [15:0] warning_index,
    input  wire  [15:0] battery_level,

    output logic out_valid,
    input  wire  out_ready,
    output logic [7:0] frame_byte,
    output logic last_byte
);
    import sfb_pkg::*;

    // Control state
    logic      busy_reg,      busy_next;
    byte_idx_t idx_reg,       idx_next;
    logic      out_valid_reg, out_valid_next;

    // Payload
    logic [PAYLOAD_W-1:0] shift_reg, shift_next;
    crc_t                 crc_reg,   crc_next;
    frame_byte_t          byte_reg,  byte_next;
    logic                 last_reg,  last_next;

    logic        advance;
    logic        at_last;
    logic        in_accept;
    frame_byte_t cur_byte;
    crc_t        crc_upd;

    // Move one byte into the output register when it is empty or being taken
    assign advance   = busy_reg && (!out_valid_reg || out_ready);
    assign at_last   = (idx_reg == IDX_CRC_LO);
    assign in_ready  = !busy_reg || (advance && at_last);
    assign in_accept = in_valid && in_ready;

    // Pick the byte for the current frame position
    always_comb
    begin
        priority if (idx_reg == IDX_SYNC0)
        begin
            cur_byte = HDR_SYNC0;
        end
        else if (idx_reg == IDX_SYNC1)
        begin
            cur_byte = HDR_SYNC1;
        end
        else if (idx_reg == IDX_LEN)
        begin
            cur_byte = HDR_LEN;
        end
        else if (idx_reg < IDX_CRC_HI)
        begin
            cur_byte = shift_reg[PAYLOAD_W-1 -: BYTE_W];
        end
        else if (idx_reg == IDX_CRC_HI)
        begin
            cur_byte = crc_reg[CRC_W-1 -: BYTE_W];
        end
        else
        begin
            cur_byte = crc_reg[BYTE_W-1:0];
        end
    end

    sfb_crc_byte u_crc (
        .crc_in  (crc_reg),
        .data    (cur_byte),
        .crc_out (crc_upd)
    );

    // Serialiser next state
    always_comb
    begin
        busy_next  = busy_reg;
        idx_next   = idx_reg;
        shift_next = shift_reg;
        crc_next   = crc_reg;

        if (advance)
        begin
            idx_next = idx_reg + 1'b1;
            if (idx_reg >= IDX_DATA0 && idx_reg < IDX_CRC_HI)
            begin
                shift_next = {shift_reg[PAYLOAD_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
            end
            if (idx_reg < IDX_CRC_HI)
            begin
                crc_next = crc_upd;
            end
            if (at_last)
            begin
                busy_next = 1'b0;
            end
        end

        // Load a fresh item; overrides the end of the previous frame
        if (in_accept)
        begin
            busy_next  = 1'b1;
            idx_next   = IDX_SYNC0;
            shift_next = {temperature, humidity, light_level, rain_index,
                          fire_index, warning_index, battery_level};
            crc_next   = CRC_INIT;
        end
    end

    // Output register next state
    always_comb
    begin
        out_valid_next = out_valid_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;

        if (advance)
        begin
            out_valid_next = 1'b1;
            byte_next      = cur_byte;
            last_next      = at_last;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= IDX_SYNC0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        crc_reg   <= crc_next;
        byte_reg  <= byte_next;
        last_reg  <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = byte_reg;
    assign last_byte  = last_reg;

endmodule

`default_nettype wire

// ----- src/sfb_checker.sv -----
`default_nettype none

module sfb_checker (
    input wire       clk,
    input wire       rst_n,
    input wire       in_valid,
    input wire       in_ready,
    input wire       out_valid,
    input wire       out_ready,
    input wire [7:0] frame_byte,
    input wire       last_byte
);

    // Hold a stalled output byte
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frame_byte) && $stable(last_byte))
        else $error("stalled output transaction changed");

    // A fresh frame is never finished in the cycle after it is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again straight after a transaction");

    // The last byte enters the output only while the next item may be taken
    a_last_with_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_byte && !$past(out_valid && last_byte) |-> $past(in_ready))
        else $error("last byte loaded without input ready");

    // Two last bytes never follow each other
    a_no_double_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_byte |=> !(out_valid && last_byte))
        else $error("last byte repeated");

endmodule

bind sensor_frame_builder_crc16 sfb_checker u_sfb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame_byte (frame_byte),
    .last_byte  (last_byte)
);

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import sfb_pkg::*;

    // Cycles with no transaction on either channel before the run is abandoned.
    // The slowest correct stretch is the long receiver hold-off plus a full
    // frame under worst-case stalls, so this leaves a wide margin.
    localparam int IDLE_LIMIT  = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER  = 30;    // items taken before the hold-off starts
    localparam int TAIL_CYCLES = 40;    // settle time after the last frame byte
    localparam int N_RANDOM    = 145;

    typedef struct {
        logic [FIELD_W-1:0] value [NUM_FIELDS];
        int                 gap;        // idle cycles before the sender offers it
    } reading_set_t;

    typedef struct {
        frame_byte_t data;
        logic        last;
    } frame_entry_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic               in_valid      = 1'b0;
    logic               in_ready;
    logic [FIELD_W-1:0] temperature   = '0;
    logic [FIELD_W-1:0] humidity      = '0;
    logic [FIELD_W-1:0] light_level   = '0;
    logic [FIELD_W-1:0] rain_index    = '0;
    logic [FIELD_W-1:0] fire_index    = '0;
    logic [FIELD_W-1:0] warning_index = '0;
    logic [FIELD_W-1:0] battery_level = '0;

    logic        out_valid;
    logic        out_ready = 1'b0;
    frame_byte_t frame_byte;
    logic        last_byte;

    // Readings still to be sent, and frame bytes the block still owes us
    reading_set_t reading_queue [$];
    frame_entry_t frame_byte_q [$];

    reading_set_t on_offer;
    reading_set_t staged_set;
    logic         staged     = 1'b0;
    int           tx_wait    = 0;
    int           rx_wait    = 0;
    int           items_taken = 0;
    int           bytes_seen  = 0;
    int           frames_seen = 0;
    int           fail_count  = 0;
    int           hold_cnt    = 0;
    logic         hold_done   = 1'b0;
    int           idle_cycles = 0;

    always #5 clk = ~clk;

    sensor_frame_builder_crc16 dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .temperature   (temperature),
        .humidity      (humidity),
        .light_level   (light_level),
        .rain_index    (rain_index),
        .fire_index    (fire_index),
        .warning_index (warning_index),
        .battery_level (battery_level),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .frame_byte    (frame_byte),
        .last_byte     (last_byte)
    );

    // Fold one byte into the reflected CRC-16, least significant bit first
    function automatic crc_t crc16_fold_byte(crc_t crc, frame_byte_t b);
        crc_t c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    // Build the 19-byte frame for one set of readings and queue every byte as
    // an expectation, in transmit order
    function automatic void push_frame_for(reading_set_t r);
        frame_byte_t  fb [FRAME_BYTES];
        crc_t         crc;
        frame_entry_t e;
        fb[IDX_SYNC0] = HDR_SYNC0;
        fb[IDX_SYNC1] = HDR_SYNC1;
        fb[IDX_LEN]   = HDR_LEN;
        for (int i = 0; i < NUM_FIELDS; i++)
        begin
            fb[IDX_DATA0 + 2 * i]     = r.value[i][15:8];
            fb[IDX_DATA0 + 2 * i + 1] = r.value[i][7:0];
        end
        // The check covers the header and all readings, not itself
        crc = CRC_INIT;
        for (int i = 0; i < IDX_CRC_HI; i++)
            crc = crc16_fold_byte(crc, fb[i]);
        fb[IDX_CRC_HI] = crc[15:8];
        fb[IDX_CRC_LO] = crc[7:0];
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            e.data = fb[i];
            e.last = (i == IDX_CRC_LO);
            frame_byte_q.push_back(e);
        end
    endfunction

    function automatic reading_set_t make_set(
        logic [15:0] t, logic [15:0] h, logic [15:0] l, logic [15:0] r,
        logic [15:0] f, logic [15:0] w, logic [15:0] b, int gap);
        reading_set_t s;
        s.value[0] = t;
        s.value[1] = h;
        s.value[2] = l;
        s.value[3] = r;
        s.value[4] = f;
        s.value[5] = w;
        s.value[6] = b;
        s.gap      = gap;
        return s;
    endfunction

    // Bias towards the corners: zero, all ones, single bits and their inverses
    function automatic logic [15:0] random_reading();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h0001 << $urandom_range(0, 15);
            3:       return ~(16'h0001 << $urandom_range(0, 15));
            default: return 16'($urandom());
        endcase
    endfunction

    // Sender gap: back-to-back bursts of 16 items alternate with random gaps
    function automatic int sender_gap(int n);
        if ((n / 16) % 2 == 0)
            return 0;
        return $urandom_range(0, 15);
    endfunction

    // Receiver stall: runs of three frames at full rate, then random stalls
    function automatic int receiver_stall(int n);
        if ((n / (3 * FRAME_BYTES)) % 3 == 0)
            return 0;
        if ($urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 15);
    endfunction

    // Driver: offer the next set of readings after its gap, keep valid and the
    // payload steady until the transaction completes
    always @(posedge clk or negedge rst_n)
    begin : drive_readings
        logic offer;
        logic present;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            offer   = in_valid;
            present = 1'b0;
            if (in_valid && in_ready)
            begin
                push_frame_for(on_offer);
                items_taken <= items_taken + 1;
                offer = 1'b0;
            end
            if (!offer)
            begin
                if (!staged && reading_queue.size() != 0)
                begin
                    staged_set = reading_queue.pop_front();
                    staged     = 1'b1;
                    tx_wait    = staged_set.gap;
                end
                if (staged)
                begin
                    if (tx_wait == 0)
                    begin
                        on_offer = staged_set;
                        staged   = 1'b0;
                        offer    = 1'b1;
                        present  = 1'b1;
                    end
                    else
                    begin
                        tx_wait--;
                    end
                end
            end
            in_valid <= offer;
            if (present)
            begin
                temperature   <= on_offer.value[0];
                humidity      <= on_offer.value[1];
                light_level   <= on_offer.value[2];
                rain_index    <= on_offer.value[3];
                fire_index    <= on_offer.value[4];
                warning_index <= on_offer.value[5];
                battery_level <= on_offer.value[6];
            end
        end
    end

    // Long receiver hold-off, counted here: once enough items have gone in,
    // drop ready for a long stretch while the sender keeps offering, so the
    // block fills up and has to stall its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_cnt != 0)
        begin
            hold_cnt <= hold_cnt - 1;
        end
        else if (!hold_done && items_taken == HOLD_AFTER)
        begin
            hold_cnt  <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Monitor: check each frame byte against the oldest expectation, then draw
    // how long to hold off before taking the next one
    always @(posedge clk or negedge rst_n)
    begin : check_frame_bytes
        frame_entry_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (frame_byte_q.size() == 0)
                begin
                    $error("frame byte %02h (last_byte %0b) with no frame pending",
                           frame_byte, last_byte);
                    fail_count++;
                end
                else
                begin
                    want = frame_byte_q.pop_front();
                    if (frame_byte !== want.data)
                    begin
                        $error("frame_byte: expected %02h, got %02h", want.data, frame_byte);
                        fail_count++;
                    end
                    if (last_byte !== want.last)
                    begin
                        $error("last_byte: expected %0b, got %0b", want.last, last_byte);
                        fail_count++;
                    end
                end
                bytes_seen++;
                if (last_byte === 1'b1)
                    frames_seen++;
                rx_wait = receiver_stall(bytes_seen);
            end
            if (rx_wait > 0)
            begin
                rx_wait--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= (hold_cnt == 0);
            end
        end
    end

    // Watchdog: abandon the run if neither channel moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", idle_cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [15:0] v [NUM_FIELDS];

        // Directed part: extremes, alternating patterns, a header look-alike,
        // each field at full scale on its own, then single-bit and mixed patterns
        reading_queue.push_back(make_set(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                         16'h0000, 16'h0000, 16'h0000, 0));
        reading_queue.push_back(make_set(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                         16'hFFFF, 16'hFFFF, 16'hFFFF, 0));
        reading_queue.push_back(make_set(16'h5555, 16'h5555, 16'h5555, 16'h5555,
                                         16'h5555, 16'h5555, 16'h5555, 0));
        reading_queue.push_back(make_set(16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA,
                                         16'hAAAA, 16'hAAAA, 16'hAAAA, 3));
        reading_queue.push_back(make_set(16'h55AA, 16'h1155, 16'hAA11, 16'h55AA,
                                         16'h1155, 16'hAA11, 16'h55AA, 0));
        reading_queue.push_back(make_set(16'h0102, 16'h0304, 16'h0506, 16'h0708,
                                         16'h090A, 16'h0B0C, 16'h0D0E, 7));
        reading_queue.push_back(make_set(16'h00FF, 16'hFF00, 16'h00FF, 16'hFF00,
                                         16'h00FF, 16'hFF00, 16'h00FF, 0));
        for (int i = 0; i < NUM_FIELDS; i++)
        begin
            foreach (v[j])
                v[j] = (j == i) ? 16'hFFFF : 16'h0000;
            reading_queue.push_back(make_set(v[0], v[1], v[2], v[3], v[4], v[5], v[6],
                                             i % 3));
        end
        reading_queue.push_back(make_set(16'h8000, 16'h0001, 16'h8000, 16'h0001,
                                         16'h8000, 16'h0001, 16'h8000, 0));
        reading_queue.push_back(make_set(16'h7FFF, 16'hFFFE, 16'h7FFF, 16'hFFFE,
                                         16'h7FFF, 16'hFFFE, 16'h7FFF, 1));
        reading_queue.push_back(make_set(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0,
                                         16'h0FED, 16'hCBA9, 16'h8765, 15));

        // Random part
        for (int n = 0; n < N_RANDOM; n++)
        begin
            foreach (v[j])
                v[j] = random_reading();
            reading_queue.push_back(make_set(v[0], v[1], v[2], v[3], v[4], v[5], v[6],
                                             sender_gap(n)));
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Hold until everything has gone in and every frame byte has come out
        while (reading_queue.size() != 0 || staged || in_valid || frame_byte_q.size() != 0)
            @(posedge clk);
        // Let any stray extra bytes show up before closing
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Summary: %0d reading sets framed, %0d frame bytes checked in %0d frames,",
                 items_taken, bytes_seen, frames_seen);
        $display("         with sender gaps, receiver stalls and one %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (fail_count == 0 && frame_byte_q.size() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ----- sensor_frame_builder_crc16.f -----
src/sfb_pkg.sv
src/sfb_crc_byte.sv
src/sensor_frame_builder_crc16.sv
src/sfb_checker.sv
tb/sv/tb.sv
